### design/srrip_pkg.sv
package srrip_pkg;

  localparam logic OP_VICTIM = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  localparam logic [1:0] RRPV_MAX  = 2'd3;
  localparam logic [1:0] RRPV_FILL = 2'd2;
  localparam logic [1:0] RRPV_HIT  = 2'd0;

  localparam int SET_IDX_W = 6;
  localparam int WAY_IDX_W = 4;

  typedef struct packed {
    logic                 opcode;
    logic [SET_IDX_W-1:0] set_index;
    logic [WAY_IDX_W-1:0] way;
    logic                 hit;
  } req_t;

  typedef struct packed {
    logic [WAY_IDX_W-1:0] victim_way;
    logic                 was_empty;
  } rsp_t;

  typedef struct packed {
    logic wr_en;
    logic rsp_valid;
  } row_ctl_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_READ
  } state_t;

endpackage

### design/srrip_replacement_unit.sv
// SRRIP replacement state for a set-associative cache.
// A transaction is taken on the rising edge where start is high and busy is
// low; req carries opcode, set_index, way and hit. A victim request
// (opcode 0) returns the lowest empty way of the set, or else ages the set
// so that some way reaches 3 and returns the lowest such way. An update
// (opcode 1) writes 0 (hit) or 2 (fill) to one way and marks it used; it
// gives no result, and an update to a way of NUM_WAYS or above is dropped.
// Each set is one row of a single-port-write memory with a registered read.
// A transaction reads its row in the accept cycle, the row is searched,
// aged and written back in the next, so busy is high for one cycle and no
// new transaction is taken until the row has been written back.
// A victim result shows on rsp with done high for exactly one cycle, from
// the edge after the accept edge. The receiver cannot stall; it must take
// the result then.
// After reset the unit walks the memory marking every way empty, one set
// per cycle: busy stays high until the last set has been written.
module srrip_replacement_unit import srrip_pkg::*; #(
  parameter int NUM_SETS = 64,
  parameter int NUM_WAYS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t req,
  output logic done,
  output rsp_t rsp
);

  localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int ROW_W = 3 * NUM_WAYS;
  localparam int SET_IN_N = 1 << SET_IDX_W;

  state_t state;
  state_t state_next;

  logic [SET_W-1:0] clr_addr;
  logic [SET_W-1:0] addr_q;
  req_t             req_q;

  logic [SET_W-1:0] set_map [SET_IN_N];
  logic             accept;

  logic             mem_wr_en;
  logic [SET_W-1:0] mem_wr_addr;
  logic [ROW_W-1:0] mem_wr_data;
  logic [ROW_W-1:0] mem_rd_data;

  logic [NUM_WAYS-1:0][1:0] row_rrpv;
  logic [NUM_WAYS-1:0]      row_empty;
  logic [NUM_WAYS-1:0][1:0] rrpv_next;
  logic [NUM_WAYS-1:0]      empty_next;
  row_ctl_t                 ctl;
  rsp_t                     rsp_next;

  // set index wraps modulo the set count
  for (genvar i = 0; i < SET_IN_N; i++) begin : g_set_map
    assign set_map[i] = SET_W'(i % NUM_SETS);
  end

  assign accept = start && (state == S_IDLE);
  assign busy   = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_addr == SET_W'(NUM_SETS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == S_CLEAR) begin
      clr_addr <= clr_addr + SET_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q  <= req;
      addr_q <= set_map[req.set_index];
    end
  end

  assign row_rrpv  = mem_rd_data[2*NUM_WAYS-1:0];
  assign row_empty = mem_rd_data[ROW_W-1:2*NUM_WAYS];

  srrip_set_logic #(
    .NUM_WAYS (NUM_WAYS)
  ) u_set_logic (
    .req        (req_q),
    .rrpv       (row_rrpv),
    .empty      (row_empty),
    .rrpv_next  (rrpv_next),
    .empty_next (empty_next),
    .ctl        (ctl),
    .rsp        (rsp_next)
  );

  always_comb begin
    if (state == S_CLEAR) begin
      mem_wr_en   = 1'b1;
      mem_wr_addr = clr_addr;
      mem_wr_data = {{NUM_WAYS{1'b1}}, {(2*NUM_WAYS){1'b0}}};
    end else begin
      mem_wr_en   = (state == S_READ) && ctl.wr_en;
      mem_wr_addr = addr_q;
      mem_wr_data = {empty_next, rrpv_next};
    end
  end

  srrip_row_mem #(
    .DEPTH (NUM_SETS),
    .WIDTH (ROW_W)
  ) u_row_mem (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (set_map[req.set_index]),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == S_READ) && ctl.rsp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_READ) && ctl.rsp_valid) begin
      rsp <= rsp_next;
    end
  end

`ifndef SYNTHESIS
  a_done_after_read: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_READ))
    else $error("result strobe without a row read");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("transaction accepted but busy not raised");

  a_clear_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR && clr_addr == SET_W'(NUM_SETS - 1)) |=> (state == S_IDLE))
    else $error("clearing pass did not end at the last set");

  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !mem_wr_en)
    else $error("memory written while idle");
`endif

endmodule

### design/srrip_row_mem.sv
module srrip_row_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 48,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### design/srrip_set_logic.sv
module srrip_set_logic import srrip_pkg::*; #(
  parameter int NUM_WAYS = 16
) (
  input  req_t                      req,
  input  logic [NUM_WAYS-1:0][1:0]  rrpv,
  input  logic [NUM_WAYS-1:0]       empty,
  output logic [NUM_WAYS-1:0][1:0]  rrpv_next,
  output logic [NUM_WAYS-1:0]       empty_next,
  output row_ctl_t                  ctl,
  output rsp_t                      rsp
);

  localparam int WAY_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;

  logic                      way_ok;
  logic                      any_empty;
  logic                      any_hi;
  logic                      any_lo;
  logic                      any_max;
  logic [1:0]                top;
  logic [1:0]                age;
  logic [NUM_WAYS-1:0][1:0]  aged;
  logic [WAY_W-1:0]          first_empty;
  logic [WAY_W-1:0]          first_max;

  assign way_ok    = ({28'd0, req.way} < 32'(NUM_WAYS));
  assign any_empty = |empty;

  // largest value of the set from three or-reductions
  always_comb begin
    any_hi  = 1'b0;
    any_lo  = 1'b0;
    any_max = 1'b0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      any_hi  = any_hi | rrpv[w][1];
      any_lo  = any_lo | rrpv[w][0];
      any_max = any_max | (rrpv[w] == RRPV_MAX);
    end
  end

  assign top = {any_hi, any_hi ? any_max : any_lo};
  assign age = RRPV_MAX - top;

  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      aged[w] = rrpv[w] + age;
    end
  end

  // lowest-numbered match wins
  always_comb begin
    first_empty = '0;
    first_max   = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (empty[w]) begin
        first_empty = WAY_W'(w);
      end
      if (aged[w] == RRPV_MAX) begin
        first_max = WAY_W'(w);
      end
    end
  end

  always_comb begin
    rrpv_next  = rrpv;
    empty_next = empty;
    ctl        = '0;
    rsp        = '0;
    if (req.opcode == OP_UPDATE) begin
      ctl.wr_en = way_ok;
      for (int w = 0; w < NUM_WAYS; w++) begin
        if ({28'd0, req.way} == 32'(w)) begin
          rrpv_next[w]  = req.hit ? RRPV_HIT : RRPV_FILL;
          empty_next[w] = 1'b0;
        end
      end
    end else if (any_empty) begin
      ctl.rsp_valid  = 1'b1;
      rsp.victim_way = WAY_IDX_W'(first_empty);
      rsp.was_empty  = 1'b1;
    end else begin
      ctl.wr_en      = 1'b1;
      ctl.rsp_valid  = 1'b1;
      rrpv_next      = aged;
      rsp.victim_way = WAY_IDX_W'(first_max);
      rsp.was_empty  = 1'b0;
    end
  end

endmodule
